[sv/pjr_pkg.sv]
`default_nettype none
package pjr_pkg;

  // grid geometry
  localparam int MAX_GRID = 128;
  localparam int ADDR_W   = $clog2(MAX_GRID);
  localparam int N_W      = ADDR_W + 1;
  localparam int CMP_W    = 16;

  // register widths and reset values
  localparam int GS_W    = 8;
  localparam int HSQ_W   = 32;
  localparam int OMEGA_W = 18;
  localparam logic [GS_W-1:0]    GRID_RESET  = 8'd128;
  localparam logic [HSQ_W-1:0]   HSQ_RESET   = 32'd1082401;
  localparam logic [OMEGA_W-1:0] OMEGA_RESET = 18'd65536;

  // register indexes on the configuration port
  localparam logic [1:0] REG_GRID_SIZE    = 2'd0;
  localparam logic [1:0] REG_H_SQUARED    = 2'd1;
  localparam logic [1:0] REG_RELAX_WEIGHT = 2'd2;

  localparam int SUM_W = 64;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic signed [31:0] psi_value;
    logic signed [31:0] vorticity_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_psi;
    logic               last_of_sweep;
    logic [SUM_W-1:0]   residual_sum;
  } out_word_t;

  typedef struct packed {
    logic rd_all;
    logic rd_prev;
    logic wr_en;
  } rb_ctl_t;

  typedef struct packed {
    logic ld_stencil;
    logic ld_eps;
    logic ld_mul;
  } relax_ctl_t;

endpackage
`default_nettype wire

[sv/pjr_rowbuf.sv]
`default_nettype none
module pjr_rowbuf import pjr_pkg::*; (
  input  wire logic              clk,
  input  wire rb_ctl_t           ctl,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire word_t             psi_wr,
  input  wire word_t             vort_wr,
  output word_t                  prev_q,
  output word_t                  older_q,
  output word_t                  vort_q
);

  word_t       prev_mem [MAX_GRID];
  // older psi row and previous vorticity row share one entry per column
  logic [63:0] ov_mem   [MAX_GRID];

  // the older row takes what the previous row held at the same column
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      prev_mem[wr_addr] <= psi_wr;
      ov_mem[wr_addr]   <= {prev_q, vort_wr};
    end
    if (ctl.rd_all || ctl.rd_prev) begin
      prev_q <= prev_mem[rd_addr];
    end
    if (ctl.rd_all) begin
      {older_q, vort_q} <= ov_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/pjr_relax.sv]
`default_nettype none
module pjr_relax import pjr_pkg::*; (
  input  wire logic               clk,
  input  wire relax_ctl_t         ctl,
  input  wire word_t              centre,
  input  wire word_t              north,
  input  wire word_t              south,
  input  wire word_t              east,
  input  wire word_t              west,
  input  wire word_t              zeta,
  input  wire logic [HSQ_W-1:0]   h_sq,
  input  wire logic [OMEGA_W-1:0] weight,
  output word_t                   new_psi,
  output logic [SUM_W-1:0]        sq_out
);

  localparam int LAP_W  = 35;
  localparam int PROD_W = HSQ_W + 33;
  localparam int HZ_W   = 33;
  localparam int EPS_W  = 36;
  localparam int CP_W   = EPS_W + OMEGA_W + 1;
  localparam int CORR_W = CP_W - 18;
  localparam int PSUM_W = CORR_W + 1;

  logic signed [LAP_W-1:0]  lap_nxt, lap_r;
  logic signed [PROD_W-1:0] hz_prod;
  logic signed [63:0]       hzp_r;
  logic signed [64:0]       hz_sum;
  logic signed [HZ_W-1:0]   hz;
  logic signed [EPS_W-1:0]  eps_nxt, eps_r;
  logic signed [CP_W-1:0]   corr_prod, corr_sum;
  logic signed [CORR_W-1:0] corr_nxt, corr_r;
  logic [EPS_W-1:0]         mag;
  logic [31:0]              mag32;
  logic [SUM_W-1:0]         sq_prod, sq_nxt, sq_r;
  logic signed [PSUM_W-1:0] psum;
  logic                     psum_fits;

  // stage 1: stencil sum and h^2 * zeta
  assign lap_nxt = LAP_W'(north) + LAP_W'(south) + LAP_W'(east) + LAP_W'(west)
                 - (LAP_W'(centre) <<< 2);
  assign hz_prod = $signed({1'b0, h_sq}) * zeta;

  // stage 2: round h^2 * zeta to Q.24, form the residual
  assign hz_sum  = {hzp_r[63], hzp_r} + 65'sd2147483648;
  assign hz      = hz_sum[64:32];
  assign eps_nxt = EPS_W'(lap_r) - EPS_W'(hz);

  // stage 3: weighted correction and squared residual
  assign corr_prod = eps_r * $signed({1'b0, weight});
  assign corr_sum  = corr_prod + CP_W'(131072);
  assign corr_nxt  = corr_sum[CP_W-1:18];
  assign mag       = eps_r[EPS_W-1] ? EPS_W'(-eps_r) : EPS_W'(eps_r);
  assign mag32     = mag[31:0];
  assign sq_prod   = mag32 * mag32;
  assign sq_nxt    = (|mag[EPS_W-1:32]) ? '1 : sq_prod;

  always_ff @(posedge clk) begin
    if (ctl.ld_stencil) begin
      lap_r <= lap_nxt;
      hzp_r <= hz_prod[63:0];
    end
    if (ctl.ld_eps) begin
      eps_r <= eps_nxt;
    end
    if (ctl.ld_mul) begin
      corr_r <= corr_nxt;
      sq_r   <= sq_nxt;
    end
  end

  // saturate centre + correction to 32 bits
  assign psum      = PSUM_W'(centre) + PSUM_W'(corr_r);
  assign psum_fits = (&psum[PSUM_W-1:31]) || !(|psum[PSUM_W-1:31]);
  assign new_psi   = psum_fits ? psum[31:0]
                   : (psum[PSUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
  assign sq_out    = sq_r;

endmodule
`default_nettype wire

[sv/pjr_outq.sv]
`default_nettype none
module pjr_outq import pjr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [1:0] push_cnt,
  input  wire out_word_t word0,
  input  wire out_word_t word1,
  output logic [1:0]     space,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  out_word_t  q_r [2];
  out_word_t  q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt, base;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign space     = 2'd2 - cnt_r;
  assign base      = cnt_r - {1'b0, pop};

  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (push_cnt != 2'd0) begin
      if (base == 2'd0) begin
        q_nxt[0] = word0;
        if (push_cnt == 2'd2) begin
          q_nxt[1] = word1;
        end
      end else begin
        q_nxt[1] = word0;
      end
    end
    cnt_nxt = base + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

endmodule
`default_nettype wire

[sv/poisson_jacobi_relaxation_sweep.sv]
// sequence: after its word is taken, an interior point walks fetch, east, residual, multiply and finish,
//   a boundary or first-row point goes from fetch to finish; results pass through the output queue registers to out_
// flow: a new word is taken only in idle, one word at a time, and finish waits for room in the output queue;
//   the sequencer walks each word through the row buffer ports and multipliers
// reset: rst_n (synchronous) restores the registers, positions and residual sum;
//   the row buffers are not cleared, no clearing pass
`default_nettype none
module poisson_jacobi_relaxation_sweep import pjr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words, raster order
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;  // centre, north, zeta back; east read issued
  localparam logic [2:0] ST_EAST  = 3'd2;  // east back; stencil sum and h^2*zeta
  localparam logic [2:0] ST_EPS   = 3'd3;  // residual
  localparam logic [2:0] ST_MUL   = 3'd4;  // correction and square
  localparam logic [2:0] ST_FIN   = 3'd5;  // push results, advance position

  logic [2:0]         state_r, state_nxt;

  // configuration registers
  logic [GS_W-1:0]    grid_r;
  logic [HSQ_W-1:0]   hsq_r;
  logic [OMEGA_W-1:0] omega_r;
  logic               cfg_wr;

  // sweep position and running sums
  logic [ADDR_W-1:0]  row_r, col_r, col_eff;
  logic [SUM_W-1:0]   acc_r, acc_upd;
  logic [SUM_W:0]     acc_sum;
  word_t              west_r;

  // current word
  word_t              psi_r, zeta_r, centre_r;

  logic [CMP_W-1:0]   gs_wide, n_wide;
  logic [N_W-1:0]     n_act;
  logic [ADDR_W-1:0]  n_m1;
  logic               in_acc, out_of_range;
  logic               has1, has2, is_final, interior;
  logic [1:0]         need, space, push_cnt;
  logic               fin_go;

  rb_ctl_t            rb_ctl;
  logic [ADDR_W-1:0]  rd_addr;
  word_t              prev_q, older_q, vort_q;

  relax_ctl_t         rx_ctl;
  word_t              relax_psi;
  logic [SUM_W-1:0]   sq;

  out_word_t          res1, res2, word0, word1;

  // ---------------------------------------------------------------------------
  // configuration port, always ready, no wait states
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_GRID_SIZE:    prdata = 32'(grid_r);
      REG_H_SQUARED:    prdata = hsq_r;
      REG_RELAX_WEIGHT: prdata = 32'(omega_r);
      default:          prdata = 32'd0;
    endcase
  end

  // active grid size, clamped to 3 .. MAX_GRID
  assign gs_wide = CMP_W'(grid_r);
  assign n_wide  = (gs_wide < CMP_W'(3)) ? CMP_W'(3)
                 : ((gs_wide > CMP_W'(MAX_GRID)) ? CMP_W'(MAX_GRID) : gs_wide);
  assign n_act   = N_W'(n_wide);
  assign n_m1    = ADDR_W'(n_wide - CMP_W'(1));

  // ---------------------------------------------------------------------------
  // input side: one word in flight at a time
  // ---------------------------------------------------------------------------
  assign in_ready     = (state_r == ST_IDLE);
  assign in_acc       = in_valid && in_ready;
  // a position past the active grid starts a fresh sweep
  assign out_of_range = ({1'b0, row_r} >= n_act) || ({1'b0, col_r} >= n_act);
  assign col_eff      = out_of_range ? '0 : col_r;

  // classification of the current word (positions already settled at accept)
  assign has1     = (row_r != '0);            // releases the point one row up
  assign has2     = (row_r == n_m1);          // last row also releases itself
  assign is_final = has2 && (col_r == n_m1);
  assign interior = (row_r > ADDR_W'(1)) && (col_r != '0) && (col_r != n_m1);
  assign need     = {1'b0, has1} + {1'b0, has2};
  assign fin_go   = (state_r == ST_FIN) && (need <= space);

  always_comb begin
    case (state_r)
      ST_IDLE:  state_nxt = in_acc ? ST_FETCH : ST_IDLE;
      ST_FETCH: state_nxt = interior ? ST_EAST : ST_FIN;
      ST_EAST:  state_nxt = ST_EPS;
      ST_EPS:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_FIN;
      ST_FIN:   state_nxt = fin_go ? ST_IDLE : ST_FIN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // row buffers: centre/north/zeta read at accept, east read while the
  // column is written back
  // ---------------------------------------------------------------------------
  assign rb_ctl.rd_all  = in_acc;
  assign rb_ctl.rd_prev = (state_r == ST_FETCH);
  assign rb_ctl.wr_en   = (state_r == ST_FETCH);
  assign rd_addr        = (state_r == ST_FETCH) ? (col_r + ADDR_W'(1)) : col_eff;

  pjr_rowbuf u_rowbuf (
    .clk     (clk),
    .ctl     (rb_ctl),
    .rd_addr (rd_addr),
    .wr_addr (col_r),
    .psi_wr  (psi_r),
    .vort_wr (zeta_r),
    .prev_q  (prev_q),
    .older_q (older_q),
    .vort_q  (vort_q)
  );

  // ---------------------------------------------------------------------------
  // stencil arithmetic
  // ---------------------------------------------------------------------------
  assign rx_ctl.ld_stencil = (state_r == ST_EAST);
  assign rx_ctl.ld_eps     = (state_r == ST_EPS);
  assign rx_ctl.ld_mul     = (state_r == ST_MUL);

  pjr_relax u_relax (
    .clk     (clk),
    .ctl     (rx_ctl),
    .centre  (centre_r),
    .north   (older_q),
    .south   (psi_r),
    .east    (prev_q),
    .west    (west_r),
    .zeta    (vort_q),
    .h_sq    (hsq_r),
    .weight  (omega_r),
    .new_psi (relax_psi),
    .sq_out  (sq)
  );

  // saturating residual sum, only interior points contribute
  assign acc_sum = {1'b0, acc_r} + {1'b0, sq};
  assign acc_upd = interior ? (acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0]) : acc_r;

  // ---------------------------------------------------------------------------
  // result words
  // ---------------------------------------------------------------------------
  always_comb begin
    res1.new_psi       = interior ? relax_psi : centre_r;
    res1.last_of_sweep = 1'b0;
    res1.residual_sum  = '0;
    res2.new_psi       = psi_r;
    res2.last_of_sweep = is_final;
    res2.residual_sum  = is_final ? acc_upd : '0;
    word0              = has1 ? res1 : res2;
    word1              = res2;
    push_cnt           = fin_go ? need : 2'd0;
  end

  pjr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .word0     (word0),
    .word1     (word1),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      grid_r  <= GRID_RESET;
      hsq_r   <= HSQ_RESET;
      omega_r <= OMEGA_RESET;
      row_r   <= '0;
      col_r   <= '0;
      acc_r   <= '0;
      west_r  <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (paddr[3:2])
          REG_GRID_SIZE: begin
            // new grid size restarts the sweep
            grid_r <= pwdata[GS_W-1:0];
            row_r  <= '0;
            col_r  <= '0;
            acc_r  <= '0;
            west_r <= '0;
          end
          REG_H_SQUARED:    hsq_r   <= pwdata[HSQ_W-1:0];
          REG_RELAX_WEIGHT: omega_r <= pwdata[OMEGA_W-1:0];
          default: ;
        endcase
      end

      if (in_acc && out_of_range) begin
        row_r  <= '0;
        col_r  <= '0;
        acc_r  <= '0;
        west_r <= '0;
      end

      if (fin_go) begin
        if (is_final) begin
          // sweep done, next word opens a new one
          row_r  <= '0;
          col_r  <= '0;
          acc_r  <= '0;
          west_r <= '0;
        end else if (col_r == n_m1) begin
          acc_r  <= acc_upd;
          col_r  <= '0;
          row_r  <= row_r + ADDR_W'(1);
          west_r <= '0;
        end else begin
          acc_r <= acc_upd;
          if (has1) begin
            west_r <= centre_r;
          end
          col_r <= col_r + ADDR_W'(1);
        end
      end
    end
  end

  // payload of the word in flight
  always_ff @(posedge clk) begin
    if (in_acc) begin
      psi_r  <= in_data.psi_value;
      zeta_r <= in_data.vorticity_value;
    end
    if (state_r == ST_FETCH) begin
      centre_r <= prev_q;
    end
  end

endmodule
`default_nettype wire
